/* design/mmp_pkg.sv */
package mmp_pkg;

  // Parse phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DATA1 = 2'd1;
  localparam logic [1:0] PH_DATA2 = 2'd2;
  localparam logic [1:0] PH_SYSEX = 2'd3;

  // Status byte values
  localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
  localparam logic [7:0] ST_NOTE_ON     = 8'h90;
  localparam logic [7:0] ST_POLY_AT     = 8'hA0;
  localparam logic [7:0] ST_CTRL_CHG    = 8'hB0;
  localparam logic [7:0] ST_PROG_CHG    = 8'hC0;
  localparam logic [7:0] ST_CHAN_AT     = 8'hD0;
  localparam logic [7:0] ST_PITCH_BEND  = 8'hE0;
  localparam logic [7:0] ST_SYSEX       = 8'hF0;
  localparam logic [7:0] ST_QFRAME      = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_EOX         = 8'hF7;
  localparam logic [7:0] ST_REALTIME    = 8'hF8;

  localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;

  // One completed message
  typedef struct packed {
    logic [7:0] status;
    logic [3:0] channel;
    logic [6:0] data1;
    logic [6:0] data2;
  } msg_t;

  function automatic logic is_one_byte_status(input logic [7:0] st);
    return (st == ST_PROG_CHG) || (st == ST_CHAN_AT) ||
           (st == ST_QFRAME) || (st == ST_SONG_SEL);
  endfunction

  function automatic logic is_two_byte_status(input logic [7:0] st);
    return (st == ST_NOTE_OFF) || (st == ST_NOTE_ON) || (st == ST_POLY_AT) ||
           (st == ST_CTRL_CHG) || (st == ST_PITCH_BEND) || (st == ST_SONG_POS);
  endfunction

endpackage

/* design/midi_message_parser.sv */
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | in_valid / in_ready | midi_byte
// result   | out       | out_valid/out_ready | msg_status, msg_channel, msg_data1, msg_data2
//
// One byte is taken every cycle unless the skid register is full; a completed
// message is registered in the result register, or in the skid register if a result waits.
// The parse state updates in the same cycle as the byte transaction; the result
// register plus a one-entry skid register let bytes keep flowing while a result
// waits. in_ready drops only while the skid register holds a result.
// rst (synchronous, active high) clears the parse state and empties both
// result registers; no clearing pass is needed.
module midi_message_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] midi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_status,
  output logic [3:0] msg_channel,
  output logic [6:0] msg_data1,
  output logic [6:0] msg_data2
);
  import mmp_pkg::*;

  // Parser state
  logic [7:0] running_status, running_status_next;
  logic       status_known, status_known_next;
  logic [3:0] chan_reg, chan_reg_next;
  logic [6:0] first_data, first_data_next;
  logic [6:0] second_data, second_data_next;
  logic [1:0] parse_phase, parse_phase_next;

  // Result path: output register and skid register
  msg_t out_msg;
  msg_t skid_msg;
  logic skid_valid;

  logic       in_accept;
  logic       out_pop;
  logic       emit;
  logic [7:0] emit_status;
  logic [6:0] data_bits;
  logic       one_byte;
  logic       two_byte;
  msg_t       new_msg;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign out_pop   = out_valid && out_ready;
  assign data_bits = midi_byte[6:0];

  // Message length lookups only count when a status is actually held
  assign one_byte = status_known && is_one_byte_status(running_status);
  assign two_byte = status_known && is_two_byte_status(running_status);

  // Decode one byte against the current parse state
  always_comb begin
    running_status_next = running_status;
    status_known_next   = status_known;
    chan_reg_next       = chan_reg;
    first_data_next     = first_data;
    second_data_next    = second_data;
    parse_phase_next    = parse_phase;
    emit                = 1'b0;
    emit_status         = running_status;

    if (midi_byte[7]) begin
      priority if (midi_byte < ST_SYSEX) begin
        // Channel voice status: latch type and channel, wait for data
        running_status_next = midi_byte & HI_NIBBLE_MASK;
        chan_reg_next       = midi_byte[3:0];
        status_known_next   = 1'b1;
        parse_phase_next    = PH_DATA1;
      end else if (midi_byte < ST_REALTIME) begin
        // System common status
        running_status_next = midi_byte;
        status_known_next   = 1'b1;
        emit_status         = midi_byte;
        priority if (midi_byte == ST_SYSEX) begin
          parse_phase_next = PH_SYSEX;
        end else if (midi_byte == ST_EOX) begin
          parse_phase_next = PH_IDLE;
          emit             = 1'b1;
        end else if (midi_byte == ST_UNDEF_F4 || midi_byte == ST_UNDEF_F5 ||
                     midi_byte == ST_TUNE_REQ) begin
          // Complete at once, phase left alone
          emit = 1'b1;
        end else begin
          parse_phase_next = PH_DATA1;
        end
      end else begin
        // Real-time byte: drop it, state untouched
      end
    end else begin
      unique case (parse_phase)
        PH_DATA1: begin
          first_data_next = data_bits;
          if (one_byte) begin
            parse_phase_next = PH_IDLE;
            emit             = 1'b1;
          end else begin
            parse_phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          second_data_next = data_bits;
          if (two_byte) begin
            parse_phase_next = PH_IDLE;
            emit             = 1'b1;
            // Note-on with zero velocity reads as note-off
            if (running_status == ST_NOTE_ON && data_bits == 7'd0) begin
              emit_status = ST_NOTE_OFF;
            end
          end else begin
            running_status_next = 8'h00;
            status_known_next   = 1'b0;
            parse_phase_next    = PH_IDLE;
          end
        end
        PH_SYSEX: begin
          // Absorb sysex payload
        end
        PH_IDLE: begin
          // Running status
          priority if (one_byte) begin
            first_data_next = data_bits;
            emit            = 1'b1;
          end else if (status_known && running_status < ST_SYSEX) begin
            first_data_next  = data_bits;
            parse_phase_next = PH_DATA2;
          end else begin
            // Stray data byte: clear the status
            running_status_next = 8'h00;
            status_known_next   = 1'b0;
            parse_phase_next    = PH_IDLE;
          end
        end
      endcase
    end
  end

  // The result carries the values as they stand after this byte
  assign new_msg.status  = emit_status;
  assign new_msg.channel = chan_reg_next;
  assign new_msg.data1   = first_data_next;
  assign new_msg.data2   = second_data_next;

  // Advance parser state on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= 8'h00;
      status_known   <= 1'b0;
      chan_reg       <= 4'd0;
      first_data     <= 7'd0;
      second_data    <= 7'd0;
      parse_phase    <= PH_IDLE;
    end else if (in_accept) begin
      running_status <= running_status_next;
      status_known   <= status_known_next;
      chan_reg       <= chan_reg_next;
      first_data     <= first_data_next;
      second_data    <= second_data_next;
      parse_phase    <= parse_phase_next;
    end
  end

  // Result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // No input transaction here; refill output from skid on pop
      if (out_pop) begin
        out_msg    <= skid_msg;
        skid_valid <= 1'b0;
      end
    end else if (in_accept && emit) begin
      if (!out_valid || out_pop) begin
        out_msg   <= new_msg;
        out_valid <= 1'b1;
      end else begin
        skid_msg   <= new_msg;
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  assign msg_status  = out_msg.status;
  assign msg_channel = out_msg.channel;
  assign msg_data1   = out_msg.data1;
  assign msg_data2   = out_msg.data2;

`ifndef SYNTH
  // Skid register is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output register is empty");

  // Every delivered message carries a status byte
  a_status_bit7: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> msg_status[7])
    else $error("result status without bit 7");

  // A real-time byte leaves the parse state untouched
  a_realtime_hold: assert property (@(posedge clk) disable iff (rst)
    (in_accept && midi_byte >= ST_REALTIME) |=>
      ($stable(running_status) && $stable(parse_phase) && $stable(status_known)))
    else $error("real-time byte changed parser state");

  // No usable status means the status register is cleared
  a_status_cleared: assert property (@(posedge clk) disable iff (rst)
    !status_known |-> (running_status == 8'h00))
    else $error("running status held without status_known");
`endif

endmodule

/* verif/midi_message_parser_tb.sv */
`timescale 1ns / 1ps

module midi_message_parser_tb;
  import mmp_pkg::*;

  // One byte to send; rows of the directed table may carry a typed-in
  // result that replaces the parser model's prediction.
  typedef struct {
    logic [7:0] b;
    bit         fixed;
    bit         emits;
    msg_t       want;
  } midi_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] midi_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] msg_status;
  logic [3:0] msg_channel;
  logic [6:0] msg_data1;
  logic [6:0] msg_data2;

  midi_message_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .midi_byte   (midi_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .msg_status  (msg_status),
    .msg_channel (msg_channel),
    .msg_data1   (msg_data1),
    .msg_data2   (msg_data2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser model state
  logic [7:0] run_status;
  bit         have_status;
  logic [3:0] chan_now;
  logic [6:0] data1_now;
  logic [6:0] data2_now;
  logic [1:0] phase_now;

  midi_item_t bytes_to_send[$];
  msg_t       msgs_due[$];
  midi_item_t cur_item;
  bit         cur_hit;
  msg_t       cur_msg;
  msg_t       exp_msg;
  int         idle_pct;
  int         stall_pct;
  int         errors = 0;
  int         n_bytes = 0;
  int         n_msgs = 0;

  logic [7:0] sys_ops [7] = '{ST_QFRAME, ST_SONG_POS, ST_SONG_SEL, ST_UNDEF_F4,
                              ST_UNDEF_F5, ST_TUNE_REQ, ST_EOX};

  // Directed rows: extremes, several message kinds, real-time bytes mid-message,
  // stray data, note-on with zero velocity, and a data pair with no
  // two-byte status behind it.
  midi_item_t dir_rows [25] = '{
    '{8'hF6, 1, 1, '{ST_TUNE_REQ, 4'h0, 7'h00, 7'h00}},  // right after reset
    '{8'hF7, 1, 1, '{ST_EOX,      4'h0, 7'h00, 7'h00}},
    '{8'h00, 1, 0, '0},                                  // stray data, no result
    '{8'h9F, 1, 0, '0},
    '{8'h7F, 1, 0, '0},
    '{8'h7F, 1, 1, '{ST_NOTE_ON,  4'hF, 7'h7F, 7'h7F}},
    '{8'h3C, 0, 0, '0},                                  // running status
    '{8'hF8, 1, 0, '0},                                  // real-time mid-message
    '{8'h00, 1, 1, '{ST_NOTE_OFF, 4'hF, 7'h3C, 7'h00}},  // zero velocity
    '{8'hC0, 0, 0, '0},
    '{8'h05, 0, 0, '0},
    '{8'h7F, 0, 0, '0},
    '{8'hF0, 0, 0, '0},
    '{8'h12, 0, 0, '0},
    '{8'hFF, 1, 0, '0},
    '{8'hF7, 0, 0, '0},
    '{8'hF2, 0, 0, '0},
    '{8'h01, 0, 0, '0},
    '{8'h02, 0, 0, '0},
    '{8'hF3, 0, 0, '0},
    '{8'h40, 0, 0, '0},
    '{8'hA5, 0, 0, '0},
    '{8'hF5, 0, 0, '0},                                  // leaves phase waiting for data
    '{8'h11, 0, 0, '0},
    '{8'h22, 0, 0, '0}                                   // second byte, no usable status
  };

  function automatic bit single_data_status();
    return have_status &&
           (run_status inside {ST_PROG_CHG, ST_CHAN_AT, ST_QFRAME, ST_SONG_SEL});
  endfunction

  // Advance the parser model by one byte; hit marks a completed message.
  task automatic parse_byte(input logic [7:0] b, output bit hit, output msg_t m);
    bit vel_zero;
    hit = 1'b0;
    vel_zero = 1'b0;
    m = '0;
    if (b[7]) begin
      if (b < ST_SYSEX) begin
        run_status = b & HI_NIBBLE_MASK;
        chan_now = b[3:0];
        have_status = 1'b1;
        phase_now = PH_DATA1;
      end else if (b < ST_REALTIME) begin
        run_status = b;
        have_status = 1'b1;
        case (b)
          ST_SYSEX: phase_now = PH_SYSEX;
          ST_EOX: begin
            phase_now = PH_IDLE;
            hit = 1'b1;
          end
          ST_UNDEF_F4, ST_UNDEF_F5, ST_TUNE_REQ: hit = 1'b1;
          default: phase_now = PH_DATA1;
        endcase
      end
    end else begin
      case (phase_now)
        PH_DATA1: begin
          data1_now = b[6:0];
          if (single_data_status()) begin
            phase_now = PH_IDLE;
            hit = 1'b1;
          end else begin
            phase_now = PH_DATA2;
          end
        end
        PH_DATA2: begin
          data2_now = b[6:0];
          if (have_status && (run_status inside {ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT,
                                                 ST_CTRL_CHG, ST_PITCH_BEND,
                                                 ST_SONG_POS})) begin
            phase_now = PH_IDLE;
            hit = 1'b1;
            vel_zero = (run_status == ST_NOTE_ON) && (b[6:0] == 7'd0);
          end else begin
            run_status = 8'h00;
            have_status = 1'b0;
            phase_now = PH_IDLE;
          end
        end
        PH_SYSEX: ;
        default: begin
          if (single_data_status()) begin
            data1_now = b[6:0];
            hit = 1'b1;
          end else if (have_status && run_status < ST_SYSEX) begin
            data1_now = b[6:0];
            phase_now = PH_DATA2;
          end else begin
            run_status = 8'h00;
            have_status = 1'b0;
            phase_now = PH_IDLE;
          end
        end
      endcase
    end
    if (hit) begin
      m.status  = vel_zero ? ST_NOTE_OFF : run_status;
      m.channel = chan_now;
      m.data1   = data1_now;
      m.data2   = data2_now;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    bytes_to_send.push_back('{b, 1'b0, 1'b0, '0});
  endtask

  // Queue mostly well-formed messages with random content, plus sysex,
  // broken sequences and raw noise. Real-time bytes do not count.
  task automatic queue_random(input int count);
    int made, pick, ndata;
    logic [7:0] st, db;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) queue_byte(ST_REALTIME + 8'($urandom_range(0, 7)));
      ndata = 0;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        st = ST_NOTE_OFF + 8'($urandom_range(0, 6) * 16) + 8'($urandom_range(0, 15));
        // drop the status byte now and then to lean on running status
        if ($urandom_range(0, 3) != 0) begin
          queue_byte(st);
          made++;
        end
        ndata = ((st & HI_NIBBLE_MASK) inside {ST_PROG_CHG, ST_CHAN_AT}) ? 1 : 2;
      end else if (pick < 82) begin
        st = sys_ops[$urandom_range(0, 6)];
        queue_byte(st);
        made++;
        if (st inside {ST_QFRAME, ST_SONG_SEL}) ndata = 1;
        else if (st == ST_SONG_POS) ndata = 2;
      end else if (pick < 88) begin
        queue_byte(ST_SYSEX);
        made++;
        repeat ($urandom_range(0, 6)) begin
          queue_byte(8'($urandom_range(0, 127)));
          made++;
        end
        if ($urandom_range(0, 3) != 0) begin
          queue_byte(ST_EOX);
          made++;
        end
      end else begin
        db = 8'($urandom_range(0, 255));
        queue_byte(db);
        if (db < ST_REALTIME) made++;
      end
      for (int i = 0; i < ndata; i++) begin
        db = 8'($urandom_range(0, 127));
        if (i == 1 && $urandom_range(0, 7) == 0) db = 8'h00;
        queue_byte(db);
        made++;
      end
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct = idle;
    stall_pct = stall;
    queue_random(count);
    while (bytes_to_send.size() != 0) @(posedge clk);
  endtask

  // Input side: on each accepted transaction advance the model and record the
  // expected message; then present the next byte or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(cur_item.b, cur_hit, cur_msg);
        n_bytes++;
        if (cur_item.fixed) begin
          if (cur_item.emits) msgs_due.push_back(cur_item.want);
        end else if (cur_hit) begin
          msgs_due.push_back(cur_msg);
        end
      end
      // hold valid and payload until the pending transaction completes
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_item = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          midi_byte <= cur_item.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each accepted message with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (msgs_due.size() == 0) begin
          $error("unexpected message: status %h channel %h data1 %h data2 %h",
                 msg_status, msg_channel, msg_data1, msg_data2);
          errors++;
        end else begin
          exp_msg = msgs_due.pop_front();
          n_msgs++;
          if (msg_status !== exp_msg.status) begin
            $error("msg_status: expected %h, got %h", exp_msg.status, msg_status);
            errors++;
          end
          if (msg_channel !== exp_msg.channel) begin
            $error("msg_channel: expected %h, got %h", exp_msg.channel, msg_channel);
            errors++;
          end
          if (msg_data1 !== exp_msg.data1) begin
            $error("msg_data1: expected %h, got %h", exp_msg.data1, msg_data1);
            errors++;
          end
          if (msg_data2 !== exp_msg.data2) begin
            $error("msg_data2: expected %h, got %h", exp_msg.data2, msg_data2);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    run_status = 8'h00;
    have_status = 1'b0;
    chan_now = 4'h0;
    data1_now = 7'h00;
    data2_now = 7'h00;
    phase_now = PH_IDLE;
    idle_pct = 32;
    stall_pct = 62;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) bytes_to_send.push_back(dir_rows[i]);
    run_phase(32, 62, 280);
    run_phase(62, 32, 285);
    run_phase(0, 0, 285);

    // drain: last byte accepted, then every expected message
    while (in_valid) @(posedge clk);
    for (int k = 0; k < 2000 && msgs_due.size() != 0; k++) @(posedge clk);
    if (msgs_due.size() != 0) begin
      $error("%0d expected messages never arrived", msgs_due.size());
    end
    repeat (8) @(posedge clk);

    $display("Run covered %0d accepted bytes and %0d checked messages", n_bytes, n_msgs);
    $display("over directed cases and three sender/receiver pacing modes");
    if (errors == 0 && msgs_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
